// File: design/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg: shared constants, types and the sine table of the plasma generator
// Holds field widths, register indexes, gradient colors and the 256-entry
// sine table that the oscillator recurrence builds at elaboration.
// ----------------------------------------------------------------------------
package ppg_pkg;

  localparam int POS_BITS            = 11;
  localparam int COORD_BITS_DEFAULT  = 11;

  localparam int TABLE_ENTRIES    = 256;
  localparam int TABLE_INDEX_BITS = $clog2(TABLE_ENTRIES);
  localparam int SINE_BITS        = 18;
  localparam int SUM3_BITS        = SINE_BITS + 2;
  localparam int LEVEL_SUM_BITS   = SINE_BITS + 3;
  localparam int LEVEL_SHIFT      = 11;
  localparam int LEVEL_BITS       = 8;

  localparam longint OSC_STEP   = 1608;
  localparam longint FRAC_ONE   = 65536;
  localparam int     FRAC_SHIFT = 16;
  localparam int     LEVEL_OFFSET = 4 * 65536;

  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y = 8'd1;
  localparam logic [POS_BITS-1:0] CENTER_X_RESET = 11'd512;
  localparam logic [POS_BITS-1:0] CENTER_Y_RESET = 11'd384;

  localparam int CHAN_BITS  = 8;
  localparam int CHANNELS   = 3;
  localparam int COLOR_BITS = CHAN_BITS * CHANNELS;
  localparam int BLEND_BITS = 2 * CHAN_BITS;

  typedef logic [CHAN_BITS-1:0] chan_t;
  // Element 2 is red, element 0 is blue, matching 0xRRGGBB.
  typedef logic [CHANNELS-1:0][CHAN_BITS-1:0] rgb_t;

  localparam chan_t CHAN_MAX = 8'd255;
  localparam logic [LEVEL_BITS-1:0] SEG1_START = 8'd85;
  localparam logic [LEVEL_BITS-1:0] SEG2_START = 8'd170;

  localparam rgb_t GRAD_MIDNIGHT = 24'h070A16;
  localparam rgb_t GRAD_VIOLET   = 24'h4A2A6A;
  localparam rgb_t GRAD_GOLD     = 24'hD4AF37;
  localparam rgb_t GRAD_WHITE    = 24'hFFF6DC;

  typedef logic signed [SINE_BITS-1:0] sine_t;
  typedef sine_t sine_table_t [TABLE_ENTRIES];

  // Magic-circle oscillator; the arithmetic shifts give floor division.
  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    longint c;
    longint s;
    c = FRAC_ONE;
    s = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl[i] = SINE_BITS'(s);
      c = c - ((OSC_STEP * s) >>> FRAC_SHIFT);
      s = s + ((OSC_STEP * c) >>> FRAC_SHIFT);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// File: design/ppg_pixel_if.sv
// ----------------------------------------------------------------------------
// ppg_pixel_if: pixel coordinate channel
// Valid/ready channel that carries one pixel coordinate per transfer.
// ----------------------------------------------------------------------------
interface ppg_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [ppg_pkg::POS_BITS-1:0] pos_x;
  logic [ppg_pkg::POS_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

// File: design/ppg_result_if.sv
// ----------------------------------------------------------------------------
// ppg_result_if: pixel color channel
// Valid/ready channel that carries one color and its level per transfer.
// ----------------------------------------------------------------------------
interface ppg_result_if;
  logic                           valid;
  logic                           ready;
  logic [ppg_pkg::COLOR_BITS-1:0] color;
  logic [ppg_pkg::LEVEL_BITS-1:0] level;

  modport source (output valid, output color, output level, input ready);
  modport sink (input valid, input color, input level, output ready);
endinterface

// File: design/ppg_cfg_if.sv
// ----------------------------------------------------------------------------
// ppg_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface ppg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ppg_pkg::CFG_INDEX_BITS-1:0] index;
  logic [ppg_pkg::POS_BITS-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/plasma_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while the result channel accepts results; the square
// root takes one pipeline stage per result bit, so its depth grows with COORD_BITS.
// Reset clears every pipeline valid bit and sets the center to (512, 384).
// Plasma pixel generator: coordinate in, clamped level and gradient color out.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_unit #(
  parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  ppg_pixel_if.sink        pixel,
  ppg_result_if.source     result,
  ppg_cfg_if.sink          cfg
);

  logic [ppg_pkg::POS_BITS-1:0] center_x;
  logic [ppg_pkg::POS_BITS-1:0] center_y;

  logic                                 geom_valid, geom_ready;
  logic [2*COORD_BITS:0]                dist_sq;
  logic signed [ppg_pkg::SUM3_BITS-1:0] geom_sum3;

  logic                                 root_valid, root_ready;
  logic [COORD_BITS:0]                  radius;
  logic signed [ppg_pkg::SUM3_BITS-1:0] root_sum3;

  // Writes to an index beyond the register list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= ppg_pkg::CENTER_X_RESET;
      center_y <= ppg_pkg::CENTER_Y_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        ppg_pkg::REG_CENTER_X: center_x <= cfg.data;
        ppg_pkg::REG_CENTER_Y: center_y <= cfg.data;
        default: ;
      endcase
    end
  end

  ppg_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pixel.valid),
    .up_ready (pixel.ready),
    .pos_x    (pixel.pos_x),
    .pos_y    (pixel.pos_y),
    .center_x (center_x),
    .center_y (center_y),
    .dn_valid (geom_valid),
    .dn_ready (geom_ready),
    .dist_sq  (dist_sq),
    .sum3     (geom_sum3)
  );

  ppg_isqrt #(
    .COORD_BITS (COORD_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .up_valid (geom_valid),
    .up_ready (geom_ready),
    .dist_sq  (dist_sq),
    .sum3_in  (geom_sum3),
    .dn_valid (root_valid),
    .dn_ready (root_ready),
    .radius   (radius),
    .sum3_out (root_sum3)
  );

  ppg_shade #(
    .COORD_BITS (COORD_BITS)
  ) u_shade (
    .clk      (clk),
    .rst      (rst),
    .up_valid (root_valid),
    .up_ready (root_ready),
    .radius   (radius),
    .sum3     (root_sum3),
    .dn_valid (result.valid),
    .dn_ready (result.ready),
    .color    (result.color),
    .level    (result.level)
  );

endmodule

// File: design/ppg_geom.sv
// ----------------------------------------------------------------------------
// ppg_geom: coordinate front end
// Three stages: deltas and table indexes, squares and three sine lookups,
// then the squared distance and the sum of the three sine values.
// ----------------------------------------------------------------------------
module ppg_geom #(
  parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [ppg_pkg::POS_BITS-1:0]          pos_x,
  input  logic [ppg_pkg::POS_BITS-1:0]          pos_y,
  input  logic [ppg_pkg::POS_BITS-1:0]          center_x,
  input  logic [ppg_pkg::POS_BITS-1:0]          center_y,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [2*COORD_BITS:0]                 dist_sq,
  output logic signed [ppg_pkg::SUM3_BITS-1:0]  sum3
);

  localparam int STAGES = 3;
  localparam int DW     = COORD_BITS + 1;
  localparam int SQ     = 2 * COORD_BITS;
  localparam int IB     = ppg_pkg::TABLE_INDEX_BITS;

  logic             valid [STAGES];
  logic [STAGES:0]  adv;

  logic [COORD_BITS-1:0]   x, y, cx, cy;
  logic [COORD_BITS+1:0]   x3;
  logic [COORD_BITS:0]     xy;
  logic [COORD_BITS+2:0]   xy3;

  logic signed [DW-1:0]    dx1, dy1;
  logic [IB-1:0]           ix1, iy1, ixy1;

  logic signed [2*DW-1:0]  prod_x, prod_y;
  logic [SQ-1:0]           sq_x2, sq_y2;
  ppg_pkg::sine_t          sin_a2, sin_b2, sin_c2;

  always_comb begin
    adv[STAGES] = dn_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        valid[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) valid[0] <= up_valid;
      if (adv[1]) valid[1] <= valid[0];
      if (adv[2]) valid[2] <= valid[1];
    end
  end

  // Only the low COORD_BITS bits of coordinates and centers take part.
  always_comb begin
    x   = COORD_BITS'(pos_x);
    y   = COORD_BITS'(pos_y);
    cx  = COORD_BITS'(center_x);
    cy  = COORD_BITS'(center_y);
    x3  = (COORD_BITS+2)'(x) + (COORD_BITS+2)'({x, 1'b0});
    xy  = (COORD_BITS+1)'(x) + (COORD_BITS+1)'(y);
    xy3 = (COORD_BITS+3)'(xy) + (COORD_BITS+3)'({xy, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx1  <= $signed({1'b0, x}) - $signed({1'b0, cx});
      dy1  <= $signed({1'b0, y}) - $signed({1'b0, cy});
      ix1  <= IB'(x3 >> 1);
      iy1  <= IB'({y, 1'b0});
      ixy1 <= IB'(xy3 >> 2);
    end
  end

  assign prod_x = dx1 * dx1;
  assign prod_y = dy1 * dy1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sq_x2  <= prod_x[SQ-1:0];
      sq_y2  <= prod_y[SQ-1:0];
      sin_a2 <= ppg_pkg::SINE_TABLE[ix1];
      sin_b2 <= ppg_pkg::SINE_TABLE[iy1];
      sin_c2 <= ppg_pkg::SINE_TABLE[ixy1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dist_sq <= (SQ+1)'(sq_x2) + (SQ+1)'(sq_y2);
      sum3    <= ppg_pkg::SUM3_BITS'(sin_a2) + ppg_pkg::SUM3_BITS'(sin_b2)
               + ppg_pkg::SUM3_BITS'(sin_c2);
    end
  end

endmodule

// File: design/ppg_isqrt.sv
// ----------------------------------------------------------------------------
// ppg_isqrt: pipelined integer square root
// One restoring root step per stage, two radicand bits per step, with the
// partial sine sum carried alongside.
// ----------------------------------------------------------------------------
module ppg_isqrt #(
  parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [2*COORD_BITS:0]                 dist_sq,
  input  logic signed [ppg_pkg::SUM3_BITS-1:0]  sum3_in,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [COORD_BITS:0]                   radius,
  output logic signed [ppg_pkg::SUM3_BITS-1:0]  sum3_out
);

  localparam int P  = COORD_BITS + 1;
  localparam int VW = 2 * P;
  localparam int SW = COORD_BITS + 5;

  logic                                 valid [P];
  logic [P:0]                           adv;
  logic [SW-1:0]                        root  [P];
  logic [SW-1:0]                        rem   [P];
  logic [VW-1:0]                        val   [P];
  logic signed [ppg_pkg::SUM3_BITS-1:0] side  [P];

  always_comb begin
    adv[P] = dn_ready;
    for (int k = P - 1; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = valid[P-1];
  assign radius   = root[P-1][COORD_BITS+1:1];
  assign sum3_out = side[P-1];

  for (genvar k = 0; k < P; k++) begin : g_step
    logic                                 v_in;
    logic [SW-1:0]                        root_in, rem_in, root_sh, rem_sh;
    logic [SW-1:0]                        root_step, rem_step;
    logic [VW-1:0]                        val_in;
    logic signed [ppg_pkg::SUM3_BITS-1:0] side_in;

    if (k == 0) begin : g_first
      assign v_in    = up_valid;
      assign root_in = '0;
      assign rem_in  = '0;
      assign val_in  = VW'(dist_sq);
      assign side_in = sum3_in;
    end else begin : g_next
      assign v_in    = valid[k-1];
      assign root_in = root[k-1];
      assign rem_in  = rem[k-1];
      assign val_in  = val[k-1];
      assign side_in = side[k-1];
    end

    always_comb begin
      root_sh   = root_in << 1;
      rem_sh    = (rem_in << 2) | SW'(val_in[VW-1-2*k -: 2]);
      root_step = root_sh;
      rem_step  = rem_sh;
      if (root_sh < rem_sh) begin
        rem_step  = rem_sh - root_sh - SW'(1);
        root_step = root_sh + SW'(2);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv[k]) begin
        valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        root[k] <= root_step;
        rem[k]  <= rem_step;
        val[k]  <= val_in;
        side[k] <= side_in;
      end
    end
  end

endmodule

// File: design/ppg_shade.sv
// ----------------------------------------------------------------------------
// ppg_shade: level and gradient back end
// Five stages: radial sine lookup, clamped level, segment choice, per-channel
// blend products, and division by 255 into the output register.
// ----------------------------------------------------------------------------
module ppg_shade #(
  parameter int COORD_BITS = ppg_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [COORD_BITS:0]                   radius,
  input  logic signed [ppg_pkg::SUM3_BITS-1:0]  sum3,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [ppg_pkg::COLOR_BITS-1:0]        color,
  output logic [ppg_pkg::LEVEL_BITS-1:0]        level
);

  localparam int STAGES = 5;
  localparam int LS     = ppg_pkg::LEVEL_SUM_BITS;
  localparam int LB     = ppg_pkg::LEVEL_BITS;
  localparam int BB     = ppg_pkg::BLEND_BITS;
  localparam int CH     = ppg_pkg::CHANNELS;

  logic             valid [STAGES];
  logic [STAGES:0]  adv;

  logic signed [ppg_pkg::SUM3_BITS-1:0] sum3_1;
  ppg_pkg::sine_t                       sin_r1;

  logic signed [LS-1:0]  total;
  logic signed [LS-1:0]  shifted;
  logic [LB-1:0]         level_next;
  logic [LB-1:0]         level2;

  ppg_pkg::rgb_t         seg_a, seg_b;
  logic [LB-1:0]         seg_off;
  ppg_pkg::chan_t        weight_next;
  ppg_pkg::rgb_t         col_a3, col_b3;
  ppg_pkg::chan_t        weight3;
  logic [LB-1:0]         level3;

  logic [CH-1:0][BB-1:0] blend_sum;
  logic [CH-1:0][BB-1:0] blend4;
  logic [LB-1:0]         level4;

  ppg_pkg::rgb_t         color_next;

  always_comb begin
    adv[STAGES] = dn_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        valid[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) valid[0] <= up_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) valid[k] <= valid[k-1];
      end
    end
  end

  // The radial index is twice the radius, modulo the table size.
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sum3_1 <= sum3;
      sin_r1 <= ppg_pkg::SINE_TABLE[ppg_pkg::TABLE_INDEX_BITS'({radius, 1'b0})];
    end
  end

  // The arithmetic shift floors negative sums before the clamp.
  always_comb begin
    total   = LS'(sum3_1) + LS'(sin_r1) + LS'(ppg_pkg::LEVEL_OFFSET);
    shifted = total >>> ppg_pkg::LEVEL_SHIFT;
    if (total < 0) begin
      level_next = '0;
    end else if (shifted > LS'(2**LB - 1)) begin
      level_next = '1;
    end else begin
      level_next = LB'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      level2 <= level_next;
    end
  end

  always_comb begin
    if (level2 < ppg_pkg::SEG1_START) begin
      seg_a   = ppg_pkg::GRAD_MIDNIGHT;
      seg_b   = ppg_pkg::GRAD_VIOLET;
      seg_off = level2;
    end else if (level2 < ppg_pkg::SEG2_START) begin
      seg_a   = ppg_pkg::GRAD_VIOLET;
      seg_b   = ppg_pkg::GRAD_GOLD;
      seg_off = level2 - ppg_pkg::SEG1_START;
    end else begin
      seg_a   = ppg_pkg::GRAD_GOLD;
      seg_b   = ppg_pkg::GRAD_WHITE;
      seg_off = level2 - ppg_pkg::SEG2_START;
    end
    weight_next = ppg_pkg::CHAN_BITS'({seg_off, 1'b0}) + ppg_pkg::CHAN_BITS'(seg_off);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      col_a3  <= seg_a;
      col_b3  <= seg_b;
      weight3 <= weight_next;
      level3  <= level2;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CH; ch++) begin
      blend_sum[ch] = BB'(col_a3[ch]) * BB'(ppg_pkg::CHAN_MAX - weight3)
                    + BB'(col_b3[ch]) * BB'(weight3);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      blend4 <= blend_sum;
      level4 <= level3;
    end
  end

  // Exact floor division by 255 for any blend sum that fits in 16 bits.
  always_comb begin
    for (int ch = 0; ch < CH; ch++) begin
      color_next[ch] = ppg_pkg::CHAN_BITS'(
        ((BB+1)'(blend4[ch]) + (BB+1)'(blend4[ch] >> 8) + (BB+1)'(1)) >> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      color <= color_next;
      level <= level4;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the plasma pixel generator
// Streams pixel coordinates through the block under several center settings
// and compares every color and level against a cycle-free model of the
// sine sum, square-root radius, level clamp and gradient blend.
// ----------------------------------------------------------------------------
module testbench;

  localparam int     PIPE_LATENCY = ppg_pkg::COORD_BITS_DEFAULT + 9;
  localparam int     DRAIN_LIMIT  = 2000;
  localparam int     CYCLE_LIMIT  = 500000;
  localparam int     SWEEP_ITEMS  = 240;
  localparam longint OSC_STEP_TB  = 1608;
  localparam longint WAVE_OFFSET  = 4 * 65536;
  localparam int     WAVE_SHIFT   = 11;
  localparam bit     SIDE_SRC     = 1'b0;
  localparam bit     SIDE_SNK     = 1'b1;

  localparam logic [ppg_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 8'd2;
  localparam logic [ppg_pkg::CFG_INDEX_BITS-1:0] REG_LAST  = 8'hFF;

  localparam logic [23:0] RGB_MIDNIGHT = 24'h070A16;
  localparam logic [23:0] RGB_VIOLET   = 24'h4A2A6A;
  localparam logic [23:0] RGB_GOLD     = 24'hD4AF37;
  localparam logic [23:0] RGB_WARM     = 24'hFFF6DC;
  localparam int          BAND_VIOLET  = 85;
  localparam int          BAND_GOLD    = 170;
  localparam int          CHAN_FULL    = 255;

  typedef struct packed {
    logic [ppg_pkg::POS_BITS-1:0] x;
    logic [ppg_pkg::POS_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [ppg_pkg::COLOR_BITS-1:0] color;
    logic [ppg_pkg::LEVEL_BITS-1:0] level;
  } plasma_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppg_pixel_if  pixel_ch ();
  ppg_result_if result_ch ();
  ppg_cfg_if    cfg_ch ();

  plasma_pixel_generator_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  int          sine_lut [ppg_pkg::TABLE_ENTRIES];
  int          center_x_now = int'(ppg_pkg::CENTER_X_RESET);
  int          center_y_now = int'(ppg_pkg::CENTER_Y_RESET);
  pixel_t      pixel_backlog [$];
  plasma_t     plasma_expect [$];
  pixel_t      next_px;
  plasma_t     want;
  int unsigned pixels_queued = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned err_count = 0;
  int unsigned centers_used = 1;
  int unsigned src_wait = 0;
  int unsigned snk_wait = 0;
  int unsigned stretch_left [2] = '{0, 0};
  bit          calm [2] = '{0, 0};
  int unsigned cycle_count = 0;
  int          level_lo = 255;
  int          level_hi = 0;

  // Waits come in stretches: some stretches run with no idling at all.
  function automatic int unsigned draw_wait(input bit side);
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(8, 64);
      calm[side] = ($urandom_range(0, 3) == 0);
    end
    stretch_left[side]--;
    return calm[side] ? 0 : $urandom_range(0, 14);
  endfunction

  // The table index wraps at the table size.
  function automatic int sine_at(input int idx);
    return sine_lut[idx[ppg_pkg::TABLE_INDEX_BITS-1:0]];
  endfunction

  function automatic int unsigned isqrt(input int unsigned v);
    int unsigned root;
    int unsigned probe;
    root = 0;
    probe = 32'h4000_0000;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // The three lookups that depend only on the coordinate.
  function automatic longint coord_wave_sum(input int xi, input int yi);
    return longint'(sine_at(xi * 3 / 2)) + longint'(sine_at(yi * 2))
         + longint'(sine_at((xi + yi) * 3 / 4));
  endfunction

  function automatic logic [23:0] blend_rgb(input logic [23:0] a, b, input int w);
    logic [23:0] mix;
    int ca;
    int cb;
    mix = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca = int'(a[8*ch +: 8]);
      cb = int'(b[8*ch +: 8]);
      mix[8*ch +: 8] = 8'((ca * (CHAN_FULL - w) + cb * w) / CHAN_FULL);
    end
    return mix;
  endfunction

  function automatic plasma_t plasma_of(input logic [ppg_pkg::POS_BITS-1:0] x, y);
    int          xi;
    int          yi;
    int          dx;
    int          dy;
    int unsigned radius;
    longint      lv;
    plasma_t     res;
    xi = int'(x);
    yi = int'(y);
    dx = xi - center_x_now;
    dy = yi - center_y_now;
    radius = isqrt(dx * dx + dy * dy);
    lv = (coord_wave_sum(xi, yi) + longint'(sine_at(int'(radius * 2))) + WAVE_OFFSET)
         >>> WAVE_SHIFT;
    if (lv < 0) lv = 0;
    else if (lv > 255) lv = 255;
    res.level = lv[7:0];
    if (lv < BAND_VIOLET) begin
      res.color = blend_rgb(RGB_MIDNIGHT, RGB_VIOLET, int'(lv) * 3);
    end else if (lv < BAND_GOLD) begin
      res.color = blend_rgb(RGB_VIOLET, RGB_GOLD, (int'(lv) - BAND_VIOLET) * 3);
    end else begin
      res.color = blend_rgb(RGB_GOLD, RGB_WARM, (int'(lv) - BAND_GOLD) * 3);
    end
    return res;
  endfunction

  function automatic void note_error(input string what, input longint exp_v, act_v);
    err_count++;
    if (err_count <= 10)
      $display("ERROR at %0t: %s expected %0h got %0h", $time, what, exp_v, act_v);
  endfunction

  function automatic void queue_pixel(input logic [ppg_pkg::POS_BITS-1:0] x, y);
    pixel_t px;
    px.x = x;
    px.y = y;
    pixel_backlog.push_back(px);
    pixels_queued++;
  endfunction

  // Mostly uniform coordinates, plus pixels near the center, on its axes
  // and at the canvas edges.
  function automatic void queue_random_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      6, 7: begin
        queue_pixel(ppg_pkg::POS_BITS'(center_x_now + $urandom_range(0, 48) - 24),
                    ppg_pkg::POS_BITS'(center_y_now + $urandom_range(0, 48) - 24));
      end
      8: begin
        queue_pixel($urandom_range(0, 1) ? '1 : '0,
                    ($urandom_range(0, 2) == 0) ? ppg_pkg::POS_BITS'($urandom)
                                                : ($urandom_range(0, 1) ? '1 : '0));
      end
      9: begin
        if ($urandom_range(0, 1)) begin
          queue_pixel(ppg_pkg::POS_BITS'(center_x_now), ppg_pkg::POS_BITS'($urandom));
        end else begin
          queue_pixel(ppg_pkg::POS_BITS'($urandom), ppg_pkg::POS_BITS'(center_y_now));
        end
      end
      default: begin
        queue_pixel(ppg_pkg::POS_BITS'($urandom), ppg_pkg::POS_BITS'($urandom));
      end
    endcase
  endfunction

  task automatic write_reg(input logic [ppg_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [ppg_pkg::POS_BITS-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == ppg_pkg::REG_CENTER_X) center_x_now = int'(val);
    else if (idx == ppg_pkg::REG_CENTER_Y) center_y_now = int'(val);
  endtask

  // The sender holds off here until every queued pixel has been accepted and
  // every expected result has come back.
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    while (pixels_sent != pixels_queued) @(posedge clk);
    while (plasma_expect.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_center(input logic [ppg_pkg::POS_BITS-1:0] cx, cy);
    write_reg(ppg_pkg::REG_CENTER_X, cx);
    write_reg(ppg_pkg::REG_CENTER_Y, cy);
    centers_used++;
  endtask

  // Pixel source.
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
      src_wait = 0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        plasma_expect.push_back(plasma_of(pixel_ch.pos_x, pixel_ch.pos_y));
        pixels_sent++;
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (src_wait != 0) begin
          src_wait--;
          pixel_ch.valid <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          next_px = pixel_backlog.pop_front();
          pixel_ch.valid <= 1'b1;
          pixel_ch.pos_x <= next_px.x;
          pixel_ch.pos_y <= next_px.y;
          src_wait = draw_wait(SIDE_SRC);
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink and checker.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (plasma_expect.size() == 0) begin
          note_error("result with nothing pending, color", 0, longint'(result_ch.color));
        end else begin
          want = plasma_expect.pop_front();
          if (result_ch.color !== want.color) begin
            note_error("color", longint'(want.color), longint'(result_ch.color));
          end
          if (result_ch.level !== want.level) begin
            note_error("level", longint'(want.level), longint'(result_ch.level));
          end
          if (int'(want.level) < level_lo) level_lo = int'(want.level);
          if (int'(want.level) > level_hi) level_hi = int'(want.level);
        end
        snk_wait = draw_wait(SIDE_SNK);
      end
      if (snk_wait != 0) begin
        snk_wait--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    longint c;
    longint s;
    longint w3;
    longint hi_sum;
    longint lo_sum;
    int     hi_x;
    int     hi_y;
    int     lo_x;
    int     lo_y;
    int     hi_r;
    int     lo_r;
    int     cx;
    int     cy;

    pixel_ch.valid  = 1'b0;
    pixel_ch.pos_x  = '0;
    pixel_ch.pos_y  = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;

    // Sine table from the magic-circle oscillator, floor division throughout.
    c = 65536;
    s = 0;
    for (int i = 0; i < ppg_pkg::TABLE_ENTRIES; i++) begin
      sine_lut[i[ppg_pkg::TABLE_INDEX_BITS-1:0]] = int'(s);
      c = c - ((OSC_STEP_TB * s) >>> 16);
      s = s + ((OSC_STEP_TB * c) >>> 16);
    end

    // Find coordinates whose three coordinate lookups peak and bottom out, and
    // radii whose lookup does the same, to push the level toward its clamps.
    hi_sum = -(64'sd1 <<< 40);
    lo_sum = 64'sd1 <<< 40;
    hi_x = 0; hi_y = 0; lo_x = 0; lo_y = 0;
    for (int x = 0; x < 256; x++) begin
      for (int y = 0; y < 256; y++) begin
        w3 = coord_wave_sum(x, y);
        if (w3 > hi_sum) begin hi_sum = w3; hi_x = x; hi_y = y; end
        if (w3 < lo_sum) begin lo_sum = w3; lo_x = x; lo_y = y; end
      end
    end
    hi_r = 0;
    lo_r = 0;
    for (int i = 0; i < ppg_pkg::TABLE_ENTRIES; i += 2) begin
      if (sine_at(i) > sine_at(2 * hi_r)) hi_r = i / 2;
      if (sine_at(i) < sine_at(2 * lo_r)) lo_r = i / 2;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset center: canvas corners, the center pixel, alternating bits, a pixel beside the center and random pixels.
    queue_pixel(11'd0, 11'd0);
    queue_pixel(11'd2047, 11'd2047);
    queue_pixel(11'd0, 11'd2047);
    queue_pixel(11'd2047, 11'd0);
    queue_pixel(ppg_pkg::CENTER_X_RESET, ppg_pkg::CENTER_Y_RESET);
    queue_pixel(11'h555, 11'h2AA);
    queue_pixel(11'h2AA, 11'h555);
    queue_pixel(ppg_pkg::CENTER_X_RESET - 11'd1, ppg_pkg::CENTER_Y_RESET - 11'd1);
    repeat (300) queue_random_pixel();
    wait_idle();

    // Writes to unknown indexes must leave the center alone.
    write_reg(REG_SPARE, ppg_pkg::POS_BITS'($urandom));
    write_reg(REG_LAST, ppg_pkg::POS_BITS'($urandom));
    queue_pixel(ppg_pkg::CENTER_X_RESET, ppg_pkg::CENTER_Y_RESET);
    queue_pixel(ppg_pkg::POS_BITS'($urandom), ppg_pkg::POS_BITS'($urandom));
    wait_idle();

    // Highest and lowest reachable levels: the radius lands on a sine extreme.
    set_center(ppg_pkg::POS_BITS'(hi_x), ppg_pkg::POS_BITS'(hi_y + hi_r));
    queue_pixel(ppg_pkg::POS_BITS'(hi_x), ppg_pkg::POS_BITS'(hi_y));
    wait_idle();
    set_center(ppg_pkg::POS_BITS'(lo_x), ppg_pkg::POS_BITS'(lo_y + lo_r));
    queue_pixel(ppg_pkg::POS_BITS'(lo_x), ppg_pkg::POS_BITS'(lo_y));
    wait_idle();

    // Sweep of centers: the four corners, then random points.
    for (int p = 0; p < 7; p++) begin
      if (p < 4) begin
        cx = (p & 1) ? 2047 : 0;
        cy = (p & 2) ? 2047 : 0;
      end else begin
        cx = $urandom_range(0, 2047);
        cy = $urandom_range(0, 2047);
      end
      set_center(ppg_pkg::POS_BITS'(cx), ppg_pkg::POS_BITS'(cy));
      if (p < 4) begin
        queue_pixel(ppg_pkg::POS_BITS'(2047 - cx), ppg_pkg::POS_BITS'(2047 - cy));
        queue_pixel(ppg_pkg::POS_BITS'(cx), ppg_pkg::POS_BITS'(cy));
      end
      repeat (SWEEP_ITEMS) queue_random_pixel();
      wait_idle();
    end

    if (plasma_expect.size() != 0) begin
      err_count += $unsigned(plasma_expect.size());
      $display("ERROR: %0d results never arrived", plasma_expect.size());
    end

    $display("Run covered %0d pixels under %0d center settings, %0d results checked.",
             pixels_sent, centers_used, results_seen);
    $display("Levels seen ranged from %0d to %0d.", level_lo, level_hi);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ppg_pkg.sv
design/ppg_pixel_if.sv
design/ppg_result_if.sv
design/ppg_cfg_if.sv
design/ppg_geom.sv
design/ppg_isqrt.sv
design/ppg_shade.sv
design/plasma_pixel_generator_unit.sv
tb/testbench.sv
